// ===== rtl/wpbt_pkg.sv =====
// Shared types and constants for the waveform peak and beat tracker.
// No dependencies; every other file imports this package.
`default_nettype none
package wpbt_pkg;
	localparam int WAVE_POINTS       = 480;
	localparam int SLOT_W            = $clog2(WAVE_POINTS);
	localparam int MAX_FRAME_SAMPLES = 2304;
	localparam int CNT_W             = 12;
	localparam int DVD_W             = 64;
	localparam int DSR_W             = 32;

	localparam logic [31:0] BEAT_FLOOR     = 32'd1000000;
	localparam logic [19:0] BPM_SCALE      = 20'd960000;
	localparam logic [31:0] AUDIO_BYTES_RST = 32'd1;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_FINISH = 1'b1
	} wpbt_op_t;

	typedef enum logic {
		KIND_FRAME = 1'b0,
		KIND_BPM   = 1'b1
	} wpbt_kind_t;

	typedef enum logic {
		REG_AUDIO_BYTES = 1'b0,
		REG_DURATION    = 1'b1
	} wpbt_reg_t;

	typedef struct packed {
		logic               operation;
		logic signed [15:0] pcm_sample;
		logic               frame_last;
		logic [31:0]        byte_position;
		logic               run_completed;
	} wpbt_in_t;

	typedef struct packed {
		logic        result_kind;
		logic [8:0]  slot_index;
		logic [7:0]  slot_value;
		logic        beat_found;
		logic [31:0] beat_time_ms;
		logic        bpm_valid;
		logic [11:0] bpm_sixteenths;
	} wpbt_out_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DSR_W-1:0] divisor;
	} wpbt_div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DVD_W-1:0]  quotient;
	} wpbt_div_rsp_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] waddr;
		logic [7:0]        wdata;
		logic [SLOT_W-1:0] raddr;
	} wpbt_mem_req_t;
endpackage
`default_nettype wire

// ===== rtl/wpbt_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Depends on wpbt_pkg for widths and the request/response structs.
`default_nettype none
module wpbt_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  wpbt_pkg::wpbt_div_req_t req,
	output wpbt_pkg::wpbt_div_rsp_t rsp
);
	import wpbt_pkg::*;

	localparam int ITER_W = $clog2(DVD_W);

	logic              busy_q;
	logic              done_q;
	logic [ITER_W-1:0] iter_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DSR_W-1:0]  rem_q;
	logic [DSR_W-1:0]  dsr_q;
	logic [DSR_W:0]    rem_sh;
	logic              ge;
	logic [DSR_W:0]    rem_diff;

	assign rem_sh   = {rem_q, quo_q[DVD_W-1]};
	assign ge       = rem_sh >= {1'b0, dsr_q};
	assign rem_diff = rem_sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= busy_q && (iter_q == ITER_W'(DVD_W - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				iter_q <= iter_q + 1'b1;
				if (iter_q == ITER_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			// The remainder stays below the divisor, so the top bit drops.
			rem_q <= ge ? rem_diff[DSR_W-1:0] : rem_sh[DSR_W-1:0];
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;
endmodule
`default_nettype wire

// ===== rtl/wpbt_wave_mem.sv =====
// Waveform slot memory: one write port, one registered read port.
// Depends on wpbt_pkg for depth and the request struct.
`default_nettype none
module wpbt_wave_mem (
	input  logic                   clk,
	input  wpbt_pkg::wpbt_mem_req_t req,
	output logic [7:0]             rdata
);
	import wpbt_pkg::*;

	logic [7:0] mem [WAVE_POINTS];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata_q <= mem[req.raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// ===== rtl/waveform_peak_and_beat_tracker.sv =====
// Top level: sample accumulation, frame-end sequencer, tempo report.
// Depends on wpbt_pkg, wpbt_div and wpbt_wave_mem.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------
//  in       | in_valid / in_ready  | in_data  (wpbt_in_t)
//  out      | out_valid / out_ready| out_data (wpbt_out_t)
//  cfg      | cfg_we               | cfg_index, cfg_wdata
//
// A mid-frame sample is accumulated without leaving the idle state. A frame end
// runs three passes through the one-bit-per-cycle divider (slot, time, mean energy)
// and five byte steps for the divide by ten of the smoothing update.
// A finish takes one divider pass (skipped when the tempo checks fail) plus a
// sweep that zeroes all 480 slots of the waveform memory.
// After reset the same sweep runs before the first item is taken.
// A stalled output holds the sequencer in its output state until taken.
`default_nettype none
module waveform_peak_and_beat_tracker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  wpbt_pkg::wpbt_in_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output wpbt_pkg::wpbt_out_t out_data,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_wdata
);
	import wpbt_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_MUL, ST_SLOT, ST_TIME, ST_ENG, ST_SMO,
		ST_BCHK, ST_BDIV, ST_OUT
	} state_t;

	state_t            state_q, ret_q;
	logic [31:0]       audio_bytes_q, dur_q;
	logic [14:0]       peak_q;
	logic [41:0]       sum_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [34:0]       smooth_q;
	logic [15:0]       beats_q;
	logic [31:0]       first_q, last_q;
	logic [SLOT_W-1:0] clr_q;
	logic [14:0]       peak_s1;
	logic [41:0]       sum_s1;
	logic [CNT_W-1:0]  cnt_s1;
	logic [31:0]       pos_s1;
	logic [63:0]       prod_q;
	logic [SLOT_W-1:0] slot_q;
	logic [31:0]       time_q;
	logic              run_done_q, beats_ok_q, dpos_q;
	logic [31:0]       d_q;
	logic [35:0]       n_q;
	logic [39:0]       sm_q;
	logic [3:0]        sm_rem_q;
	logic [2:0]        sm_step_q;
	wpbt_out_t         res_q;
	wpbt_out_t         out_q;
	logic              out_v_q;

	wpbt_div_req_t div_req;
	wpbt_div_rsp_t div_rsp;
	wpbt_mem_req_t mem_req;
	logic [7:0]    mem_rd;

	wpbt_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));
	wpbt_wave_mem u_mem (.clk(clk), .req(mem_req), .rdata(mem_rd));

	logic              accept;
	logic [15:0]       mag;
	logic [14:0]       pk;
	logic [31:0]       sq;
	logic              take;
	logic [14:0]       peak_n;
	logic [41:0]       sum_n;
	logic [CNT_W-1:0]  cnt_n;
	logic [31:0]       divq;
	logic [30:0]       e_val;
	logic              beat;
	logic [7:0]        pb;
	logic [7:0]        merged;
	logic              bpm_ok;
	logic              out_free;
	logic [11:0]       sm_chunk;
	logic [23:0]       sm_prod;
	logic [7:0]        sm_digit;
	logic [11:0]       sm_back;
	logic [39:0]       sm_next;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_v_q || out_ready;
	assign divq     = (audio_bytes_q == 32'd0) ? 32'd1 : audio_bytes_q;

	// -32768 has magnitude 32768 for energy but saturates to 32767 for the peak.
	assign mag  = in_data.pcm_sample[15] ? (16'd0 - in_data.pcm_sample) : in_data.pcm_sample;
	assign pk   = mag[15] ? 15'h7FFF : mag[14:0];
	assign sq   = mag * mag;
	assign take = cnt_q < CNT_W'(MAX_FRAME_SAMPLES);
	assign peak_n = (take && pk > peak_q) ? pk : peak_q;
	assign sum_n  = take ? sum_q + 42'(sq) : sum_q;
	assign cnt_n  = take ? cnt_q + 1'b1 : cnt_q;

	assign e_val  = div_rsp.quotient[30:0];
	assign beat   = ({e_val, 5'd0} > (37'(smooth_q) + {smooth_q, 1'b0}))
		&& (e_val > BEAT_FLOOR[30:0]);
	assign pb     = peak_s1[14:7];
	assign merged = (pb > mem_rd) ? pb : mem_rd;
	assign bpm_ok = run_done_q && beats_ok_q && dpos_q
		&& (44'(n_q) >= 44'(d_q) * 44'd960) && (44'(n_q) <= 44'(d_q) * 44'd3200);

	// Divide by ten one byte per cycle: the running remainder and the next byte
	// form a chunk below 2560, whose tenth is exact by reciprocal multiplication.
	assign sm_chunk = {sm_rem_q, sm_q[39:32]};
	assign sm_prod  = 24'(sm_chunk) * 24'd6554;
	assign sm_digit = sm_prod[23:16];
	assign sm_back  = sm_chunk - 12'(sm_digit) * 12'd10;
	assign sm_next  = {sm_q[31:0], sm_digit};

	always_comb begin
		div_req = '0;
		case (state_q)
			ST_MUL: begin
				div_req.start    = 1'b1;
				div_req.dividend = 64'(pos_s1 * 41'(WAVE_POINTS));
				div_req.divisor  = divq;
			end
			ST_SLOT: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = prod_q;
				div_req.divisor  = divq;
			end
			ST_TIME: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = 64'(sum_s1);
				div_req.divisor  = (cnt_s1 == '0) ? 32'd1 : 32'(cnt_s1);
			end
			ST_BCHK: begin
				div_req.start    = bpm_ok;
				div_req.dividend = 64'(n_q);
				div_req.divisor  = d_q;
			end
			default: div_req = '0;
		endcase
	end

	always_comb begin
		mem_req       = '0;
		mem_req.raddr = slot_q;
		if (state_q == ST_CLEAR) begin
			mem_req.we    = 1'b1;
			mem_req.waddr = clr_q;
			mem_req.wdata = 8'd0;
		end else if (state_q == ST_ENG && div_rsp.done) begin
			mem_req.we    = 1'b1;
			mem_req.waddr = slot_q;
			mem_req.wdata = merged;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			ret_q         <= ST_IDLE;
			audio_bytes_q <= AUDIO_BYTES_RST;
			dur_q         <= '0;
			peak_q        <= '0;
			sum_q         <= '0;
			cnt_q         <= '0;
			smooth_q      <= '0;
			beats_q       <= '0;
			first_q       <= '0;
			last_q        <= '0;
			clr_q         <= '0;
			out_v_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_AUDIO_BYTES) audio_bytes_q <= cfg_wdata;
				else dur_q <= cfg_wdata;
			end
			if (state_q == ST_OUT && out_free) out_v_q <= 1'b1;
			else if (out_ready) out_v_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SLOT_W'(WAVE_POINTS - 1)) begin
						clr_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && in_data.operation == OP_FINISH) begin
						peak_q   <= '0;
						sum_q    <= '0;
						cnt_q    <= '0;
						smooth_q <= '0;
						beats_q  <= '0;
						first_q  <= '0;
						last_q   <= '0;
						ret_q    <= ST_CLEAR;
						state_q  <= ST_BCHK;
					end else if (accept && in_data.frame_last) begin
						peak_q  <= '0;
						sum_q   <= '0;
						cnt_q   <= '0;
						ret_q   <= ST_IDLE;
						state_q <= ST_MUL;
					end else if (accept) begin
						peak_q <= peak_n;
						sum_q  <= sum_n;
						cnt_q  <= cnt_n;
					end
				end
				ST_MUL: state_q <= ST_SLOT;
				ST_SLOT: if (div_rsp.done) state_q <= ST_TIME;
				ST_TIME: if (div_rsp.done) state_q <= ST_ENG;
				ST_ENG: begin
					if (div_rsp.done) begin
						if (beat) begin
							if (beats_q == '0) first_q <= time_q;
							last_q <= time_q;
							if (beats_q != 16'hFFFF) beats_q <= beats_q + 1'b1;
						end
						state_q <= ST_SMO;
					end
				end
				ST_SMO: begin
					// Five byte steps cover the 40-bit dividend.
					if (sm_step_q == 3'd4) begin
						smooth_q <= sm_next[34:0];
						state_q  <= ST_OUT;
					end
				end
				ST_BCHK: state_q <= bpm_ok ? ST_BDIV : ST_OUT;
				ST_BDIV: if (div_rsp.done) state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) state_q <= ret_q;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers that need no reset.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			if (in_data.operation == OP_FINISH) begin
				run_done_q <= in_data.run_completed;
				beats_ok_q <= beats_q > 16'd10;
				dpos_q     <= last_q > first_q;
				d_q        <= last_q - first_q;
				n_q        <= 36'(beats_q - 16'd1) * 36'(BPM_SCALE);
				res_q      <= '{result_kind: KIND_BPM, default: '0};
			end else begin
				peak_s1 <= peak_n;
				sum_s1  <= sum_n;
				cnt_s1  <= cnt_n;
				pos_s1  <= in_data.byte_position;
			end
		end
		if (state_q == ST_MUL) prod_q <= pos_s1 * dur_q;
		if (state_q == ST_SLOT && div_rsp.done) begin
			slot_q <= (div_rsp.quotient >= 64'(WAVE_POINTS))
				? SLOT_W'(WAVE_POINTS - 1) : div_rsp.quotient[SLOT_W-1:0];
		end
		if (state_q == ST_TIME && div_rsp.done) begin
			time_q <= (div_rsp.quotient[63:32] != '0) ? 32'hFFFF_FFFF
				: div_rsp.quotient[31:0];
		end
		if (state_q == ST_ENG && div_rsp.done) begin
			res_q <= '{result_kind: KIND_FRAME, slot_index: 9'(slot_q),
				slot_value: merged, beat_found: beat, beat_time_ms: time_q,
				bpm_valid: 1'b0, bpm_sixteenths: 12'd0};
			sm_q      <= 40'({e_val, 7'd0}) + 40'({e_val, 4'd0}) + 40'(smooth_q);
			sm_rem_q  <= '0;
			sm_step_q <= '0;
		end
		if (state_q == ST_SMO) begin
			sm_q      <= sm_next;
			sm_rem_q  <= sm_back[3:0];
			sm_step_q <= sm_step_q + 1'b1;
		end
		if (state_q == ST_BDIV && div_rsp.done) begin
			res_q <= '{result_kind: KIND_BPM, bpm_valid: 1'b1,
				bpm_sixteenths: div_rsp.quotient[11:0], default: '0};
		end
		if (state_q == ST_OUT && out_free) out_q <= res_q;
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");
	a_ready_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !div_rsp.busy)
		else $error("input taken while divider busy");
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_OUT))
		else $error("result raised outside output state");
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (mem_req.we && mem_req.wdata == 8'd0))
		else $error("clear sweep wrote nonzero");
endmodule
`default_nettype wire

// ===== verif/waveform_peak_and_beat_tracker_tb.sv =====
// Self-checking testbench for the waveform peak and beat tracker.
// Depends on wpbt_pkg and the RTL. Directed table and edge cases first, then random PCM tracks.
`timescale 1ns / 100ps
module waveform_peak_and_beat_tracker_tb;
	import wpbt_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	wpbt_in_t  in_data;
	logic      out_valid;
	logic      out_ready;
	wpbt_out_t out_data;
	logic      cfg_we;
	logic      cfg_index;
	logic [31:0] cfg_wdata;

	waveform_peak_and_beat_tracker dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	// Tracker state mirrored for prediction.
	logic [31:0] m_audio_bytes, m_duration;
	logic [7:0]  m_wave [WAVE_POINTS];
	longint unsigned m_peak, m_energy, m_count, m_smooth;
	longint unsigned m_beats, m_first, m_last;

	wpbt_out_t results_due [$];
	int errors, items_sent, frames_seen, beats_seen_tb, bpm_valid_seen, finishes;
	bit burst;

	logic [31:0] ab_set [5];
	logic [31:0] dur_set [5];

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("Timeout with %0d results outstanding", results_due.size());
		$display("Some tests failed");
		$finish;
	end

	task automatic report(string what, longint unsigned got, longint unsigned want);
		errors++;
		$display("%t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
	endtask

	function automatic void clear_tracker();
		foreach (m_wave[i]) m_wave[i] = 8'd0;
		m_peak = 0; m_energy = 0; m_count = 0; m_smooth = 0;
		m_beats = 0; m_first = 0; m_last = 0;
	endfunction

	// Returns 1 and fills r when the item yields a result.
	function automatic bit track_item(wpbt_in_t it, output wpbt_out_t r);
		longint unsigned div, mag, pk, slot, t, e, d, n, cnt;
		logic [7:0] pb;
		bit beat;
		r = '0;
		div = (m_audio_bytes == 0) ? 1 : m_audio_bytes;
		if (it.operation == OP_FINISH) begin
			r.result_kind = KIND_BPM;
			if (it.run_completed && m_beats > 10 && m_last > m_first) begin
				d = m_last - m_first;
				n = (m_beats - 1) * 960000;
				if (n >= 960 * d && n <= 3200 * d) begin
					r.bpm_valid = 1'b1;
					r.bpm_sixteenths = 12'(n / d);
				end
			end
			clear_tracker();
			return 1;
		end
		if (m_count < MAX_FRAME_SAMPLES) begin
			mag = it.pcm_sample[15] ? 32'h10000 - {16'd0, it.pcm_sample} : {16'd0, it.pcm_sample};
			pk = (mag > 32767) ? 32767 : mag;
			if (pk > m_peak) m_peak = pk;
			m_energy += mag * mag;
			m_count++;
		end
		if (!it.frame_last) return 0;
		slot = longint'(it.byte_position) * WAVE_POINTS / div;
		t = longint'(it.byte_position) * longint'(m_duration) / div;
		if (slot >= WAVE_POINTS) slot = WAVE_POINTS - 1;
		if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
		pb = 8'(m_peak >> 7);
		if (pb > m_wave[slot]) m_wave[slot] = pb;
		cnt = (m_count == 0) ? 1 : m_count;
		e = m_energy / cnt;
		beat = (32 * e > 3 * m_smooth) && (e > 1000000);
		if (beat) begin
			if (m_beats == 0) m_first = t;
			m_last = t;
			if (m_beats < 65535) m_beats++;
		end
		m_smooth = (144 * e + m_smooth) / 10;
		r.result_kind = KIND_FRAME;
		r.slot_index = 9'(slot);
		r.slot_value = m_wave[slot];
		r.beat_found = beat;
		r.beat_time_ms = 32'(t);
		m_peak = 0; m_energy = 0; m_count = 0;
		return 1;
	endfunction

	// Drives one item; a typed expectation replaces the predicted one.
	task automatic send(wpbt_in_t it, bit typed = 0, wpbt_out_t typed_res = '0);
		int gap;
		wpbt_out_t r;
		gap = burst ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if (track_item(it, r))
			results_due.push_back(typed ? typed_res : r);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		// A frame end or finish may still be running in the block.
		repeat (600) @(posedge clk);
	endtask

	task automatic write_reg(wpbt_reg_t idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == REG_AUDIO_BYTES) m_audio_bytes = val;
		else m_duration = val;
	endtask

	function automatic wpbt_in_t pcm(logic signed [15:0] s, bit last, logic [31:0] pos);
		wpbt_in_t it;
		it = '0;
		it.operation = OP_SAMPLE;
		it.pcm_sample = s;
		it.frame_last = last;
		it.byte_position = pos;
		it.run_completed = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic wpbt_in_t finish_item(bit done);
		wpbt_in_t it;
		it = '0;
		it.operation = OP_FINISH;
		it.pcm_sample = 16'($urandom);
		it.frame_last = 1'($urandom_range(0, 1));
		it.byte_position = $urandom;
		it.run_completed = done;
		return it;
	endfunction

	task automatic send_frame(int len, bit loud, logic [31:0] pos);
		logic signed [15:0] s;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 7) == 0) s = 16'($urandom);
			else if (loud) s = 16'($urandom_range(4000, 32767));
			else s = 16'($urandom_range(0, 300));
			if ($urandom_range(0, 1)) s = -s;
			send(pcm(s, i == len - 1, (i == len - 1) ? pos : $urandom));
		end
	endtask

	// A well-formed track: a loud frame every third frame gives a steady tempo.
	task automatic send_track(int n_beats);
		logic [31:0] pos;
		int step;
		pos = $urandom_range(0, 2000);
		step = $urandom_range(100, 200);
		for (int f = 0; f < 3 * n_beats; f++) begin
			pos += step + (($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : 0);
			if ($urandom_range(0, 15) == 0) send_frame($urandom_range(1, 6),
				1'($urandom_range(0, 1)), $urandom);
			else send_frame($urandom_range(1, 5), f % 3 == 0, pos);
		end
		send(finish_item($urandom_range(0, 5) != 0));
	endtask

	typedef struct {
		wpbt_in_t  it;
		bit        typed;
		wpbt_out_t res;
	} stim_row_t;

	always @(posedge clk) begin
		wpbt_out_t want;
		if (out_valid && out_ready) begin
			if (results_due.size() == 0) begin
				report("unexpected result", 1, 0);
			end else begin
				want = results_due.pop_front();
				if (out_data.result_kind !== want.result_kind)
					report("result_kind", out_data.result_kind, want.result_kind);
				if (out_data.slot_index !== want.slot_index)
					report("slot_index", out_data.slot_index, want.slot_index);
				if (out_data.slot_value !== want.slot_value)
					report("slot_value", out_data.slot_value, want.slot_value);
				if (out_data.beat_found !== want.beat_found)
					report("beat_found", out_data.beat_found, want.beat_found);
				if (out_data.beat_time_ms !== want.beat_time_ms)
					report("beat_time_ms", out_data.beat_time_ms, want.beat_time_ms);
				if (out_data.bpm_valid !== want.bpm_valid)
					report("bpm_valid", out_data.bpm_valid, want.bpm_valid);
				if (out_data.bpm_sixteenths !== want.bpm_sixteenths)
					report("bpm_sixteenths", out_data.bpm_sixteenths, want.bpm_sixteenths);
				if (want.result_kind == KIND_FRAME) begin
					frames_seen++;
					beats_seen_tb += want.beat_found;
				end else begin
					finishes++;
					bpm_valid_seen += want.bpm_valid;
				end
			end
		end
	end

	initial begin
		int w;
		forever begin
			w = burst ? 0 : $urandom_range(0, 8);
			if (w > 0) begin
				out_ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		stim_row_t rows [$];
		wpbt_out_t x;
		int ph;

		ab_set = '{32'd48000, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd44100};
		dur_set = '{32'd60000, 32'hFFFF_FFFF, 32'd0, 32'd1000, 32'd180000};
		arst_n = 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_AUDIO_BYTES;
		cfg_wdata <= '0;
		burst = 0;
		m_audio_bytes = AUDIO_BYTES_RST;
		m_duration = 0;
		clear_tracker();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// With reset registers every frame maps to slot 0 (position 0) or the last slot.
		x = '0; x.result_kind = KIND_FRAME; x.slot_value = 8'd255; x.beat_found = 1'b1;
		rows.push_back('{pcm(16'sd32767, 1, 32'd0), 1, x});
		x = '0; x.result_kind = KIND_BPM;
		rows.push_back('{finish_item(1), 1, x});
		rows.push_back('{pcm(16'sd0, 0, 32'hFFFF_FFFF), 0, x});
		rows.push_back('{pcm(16'sd1, 0, 32'd0), 0, x});
		rows.push_back('{pcm(-16'sd1, 0, 32'h5555_5555), 0, x});
		rows.push_back('{pcm(-16'sd32768, 0, 32'hAAAA_AAAA), 0, x});
		rows.push_back('{pcm(16'sh5555, 0, 32'd0), 0, x});
		rows.push_back('{pcm(16'shAAAA, 1, 32'hFFFF_FFFF), 0, x});
		// Negative full scale alone: peak saturates to 32767, and its energy is a beat.
		x = '0; x.result_kind = KIND_FRAME; x.slot_index = 9'(WAVE_POINTS - 1);
		x.slot_value = 8'd255; x.beat_found = 1'b1;
		rows.push_back('{pcm(-16'sd32768, 1, 32'd7), 1, x});
		rows.push_back('{pcm(16'sd0, 1, 32'd0), 0, x});
		rows.push_back('{pcm(16'sd1000, 1, 32'd3), 0, x});
		rows.push_back('{pcm(-16'sd1001, 1, 32'd3), 0, x});
		rows.push_back('{finish_item(0), 0, x});
		rows.push_back('{pcm(16'sd12345, 0, 32'd0), 0, x});
		// A partial frame is dropped by the finish.
		x = '0; x.result_kind = KIND_BPM;
		rows.push_back('{finish_item(1), 1, x});
		rows.push_back('{pcm(16'sd200, 1, 32'd1), 0, x});
		foreach (rows[i]) send(rows[i].it, rows[i].typed, rows[i].res);
		settle();

		// Zero divisor and the widest duration.
		write_reg(REG_AUDIO_BYTES, 32'd0);
		write_reg(REG_DURATION, 32'hFFFF_FFFF);
		send(pcm(-16'sd20000, 1, 32'd0));
		send(pcm(16'sd20000, 1, 32'hFFFF_FFFF));
		send(pcm(16'sd5, 1, 32'd1));
		// Overlong frame: samples past the limit are not accumulated.
		burst = 1;
		for (int i = 0; i < MAX_FRAME_SAMPLES + 8; i++)
			send(pcm((i < MAX_FRAME_SAMPLES) ? 16'sd10 : 16'sh7FFF,
				i == MAX_FRAME_SAMPLES + 7, 32'd99));
		burst = 0;
		send(finish_item(1));
		settle();

		ph = 0;
		while (items_sent < MAX_FRAME_SAMPLES + 1500) begin
			write_reg(REG_AUDIO_BYTES, (ph % 3 == 0) ? 32'd48000 : ab_set[ph % 5]);
			write_reg(REG_DURATION, (ph % 3 == 0) ? 32'd60000 : dur_set[ph % 5]);
			for (int k = 0; k < 2; k++) begin
				burst = ($urandom_range(0, 3) == 0);
				send_track($urandom_range(8, 16));
			end
			burst = 0;
			// Sender holds off until the block has drained.
			settle();
			ph++;
		end
		in_valid <= 1'b0;

		while (results_due.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		$display("Sent %0d items over %0d register settings: %0d frames, %0d beats,",
			items_sent, ph + 2, frames_seen, beats_seen_tb);
		$display("%0d tempo reports of which %0d valid", finishes, bpm_valid_seen);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
